FILE: rtl/agl_pkg.sv
// shared constants and types for the anagram group letter counter
package agl_pkg;
	localparam int MaxGroups = 64;
	localparam int MaxWordLen = 63;
	localparam int AlphabetSize = 26;
	localparam int CntW = 6;
	localparam int GrpW = 6;
	localparam int UsedW = 7;
	localparam int SigW = CntW * AlphabetSize;
	localparam int QDepth = 2;

	typedef logic [SigW-1:0] sig_t;

	typedef struct packed {
		sig_t sig;
		logic sat;
	} word_t;

	typedef struct packed {
		logic [GrpW-1:0] idx;
		logic            is_new;
		logic            full;
		logic            sat;
	} res_t;
endpackage

FILE: rtl/agl_front.sv
// front end: counts letters of the current word and emits a signature at word end
module agl_front import agl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [4:0]  letter,
	input  logic        letter_valid,
	input  logic        word_end,
	output logic        push,
	output word_t       push_word
);
	logic [CntW-1:0] cnt_q [AlphabetSize];
	logic            sat_q;
	logic [CntW-1:0] nxt [AlphabetSize];
	logic            nsat;

	always_comb begin
		nsat = sat_q;
		for (int i = 0; i < AlphabetSize; i++) begin
			nxt[i] = cnt_q[i];
			if (letter_valid && letter == 5'(i)) begin
				if (cnt_q[i] >= CntW'(MaxWordLen)) nsat = 1'b1;
				else nxt[i] = cnt_q[i] + CntW'(1);
			end
		end
		for (int i = 0; i < AlphabetSize; i++) push_word.sig[i*CntW +: CntW] = nxt[i];
		push_word.sat = nsat;
		push = take && word_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AlphabetSize; i++) cnt_q[i] <= '0;
			sat_q <= 1'b0;
		end else if (take) begin
			for (int i = 0; i < AlphabetSize; i++) cnt_q[i] <= word_end ? '0 : nxt[i];
			sat_q <= word_end ? 1'b0 : nsat;
		end
	end
endmodule

FILE: rtl/agl_queue.sv
// short fifo of finished word signatures between front and back
module agl_queue import agl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  word_t push_word,
	input  logic  pop,
	output logic  not_empty,
	output logic  full,
	output word_t head
);
	word_t          mem_q [QDepth];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;

	assign not_empty = cnt_q != 2'd0;
	assign full = cnt_q == 2'(QDepth);
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

FILE: rtl/agl_back.sv
// back end: searches stored signatures one group at a time (a memory read, then a compare) and reports the group
module agl_back import agl_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            avail,
	input  word_t           word,
	output logic            pop,
	output logic            done,
	output res_t            res
);
	typedef enum logic [1:0] {IDLE, READ, CMP} state_t;
	state_t           state_q;
	sig_t             mem [MaxGroups];
	sig_t             rd_q;
	logic [UsedW-1:0] used_q;
	logic [UsedW-1:0] g_q;
	logic             first, hit, last;

	// the very first word after reset is stored at once, nothing to search
	assign first = (state_q == IDLE) && avail && (used_q == '0);
	assign hit = rd_q == word.sig;
	assign last = (g_q + UsedW'(1)) >= used_q;
	assign pop = first || ((state_q == CMP) && (hit || last));

	always_ff @(posedge clk) begin
		rd_q <= mem[g_q[GrpW-1:0]];
		if (first) mem[0] <= word.sig;
		else if (state_q == CMP && !hit && last && used_q < UsedW'(MaxGroups))
			mem[used_q[GrpW-1:0]] <= word.sig;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			used_q <= '0;
			g_q <= '0;
			done <= 1'b0;
			res <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				IDLE: begin
					g_q <= '0;
					if (first) begin
						used_q <= UsedW'(1);
						done <= 1'b1;
						res <= '{idx: '0, is_new: 1'b1, full: 1'b0, sat: word.sat};
					end else if (avail) state_q <= READ;
				end
				READ: state_q <= CMP;
				CMP: begin
					if (hit) begin
						done <= 1'b1;
						res <= '{idx: g_q[GrpW-1:0], is_new: 1'b0, full: 1'b0, sat: word.sat};
						state_q <= IDLE;
					end else if (last) begin
						done <= 1'b1;
						if (used_q < UsedW'(MaxGroups)) begin
							res <= '{idx: used_q[GrpW-1:0], is_new: 1'b1, full: 1'b0,
								sat: word.sat};
							used_q <= used_q + UsedW'(1);
						end else
							res <= '{idx: '0, is_new: 1'b0, full: 1'b1, sat: word.sat};
						state_q <= IDLE;
					end else begin
						g_q <= g_q + UsedW'(1);
						state_q <= READ;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/anagram_group_letter_count.sv
// top level of the anagram group letter counter
// usage:
//  - drive letter, letter_valid and word_end with start high; a beat is
//    taken at a rising edge where start is high and busy is low
//  - letter beats are counted at once; a letter code of 26 or more is
//    ignored, counts saturate at 63
//  - a beat with word_end set closes the word; its signature goes into a
//    two-entry queue and the back end searches the stored signatures one
//    group at a time (one memory read, one compare)
//  - with the back end idle, a word end is answered after k groups are
//    compared, k being the matching group's index plus one, or groups_used
//    when nothing matches; the first word after reset is stored without a
//    search
//  - throughput: one letter per cycle while busy is low; the back end's
//    search of up to 64 groups for a word end overlaps later letters
//  - busy rises only when the signature queue holds two words
//  - the receiver cannot stall; each done beat must be taken as shown
//  - reset clears the counts, the group count and the queue; the signature
//    memory is not cleared, only entries below the group count are read
module anagram_group_letter_count import agl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [4:0] letter,
	input  logic       letter_valid,
	input  logic       word_end,
	output logic       done,
	output logic [5:0] group_index,
	output logic       new_group,
	output logic       table_full,
	output logic       count_saturated
);
	logic  take, push, pop, avail, qfull;
	word_t push_word, head;
	res_t  res;

	// hold off new beats while the queue cannot take a word end
	assign busy = qfull;
	assign take = start && !busy;

	agl_front u_front (.clk, .arst_n, .take, .letter, .letter_valid, .word_end,
		.push, .push_word);

	// the word leaves the queue when its result is decided
	agl_queue u_queue (.clk, .arst_n, .push, .push_word, .pop, .not_empty(avail),
		.full(qfull), .head);

	// the back end pops at its final compare, or at once for the first word
	agl_back u_back (.clk, .arst_n, .avail, .word(head), .pop, .done, .res);

	assign group_index = res.idx;
	assign new_group = res.is_new;
	assign table_full = res.full;
	assign count_saturated = res.sat;
endmodule

FILE: verif/anagram_group_letter_count_test.sv
// testbench for the anagram group letter counter: directed and random words checked against a predictor
module anagram_group_letter_count_test import agl_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 2000;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [4:0] letter;
	logic       letter_valid;
	logic       word_end;
	logic       done;
	logic [5:0] group_index;
	logic       new_group;
	logic       table_full;
	logic       count_saturated;

	anagram_group_letter_count dut (.*);

	// predictor state: counts of the open word, stored signatures, groups in use
	logic [CntW-1:0] word_counts [AlphabetSize];
	logic [CntW-1:0] known_sigs [MaxGroups][AlphabetSize];
	int              groups_seen;
	logic            word_sat;

	// expected group answers, oldest first
	res_t group_answers [$];
	int   fail_count;
	int   idle_cycles;
	int   words_sent;
	int   beats_sent;
	int   full_hits;
	int   sat_hits;
	bit   no_gaps;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// fold one beat into the predictor; a word end yields one expected answer
	function automatic void predict_beat(logic [4:0] code, logic vld, logic fin);
		res_t r;
		bit   hit;
		bit   same;
		if (vld && code < AlphabetSize) begin
			if (word_counts[code] >= MaxWordLen)
				word_sat = 1'b1;
			else
				word_counts[code]++;
		end
		if (!fin)
			return;
		r = '0;
		hit = 1'b0;
		for (int g = 0; g < groups_seen && !hit; g++) begin
			same = 1'b1;
			for (int i = 0; i < AlphabetSize; i++)
				if (known_sigs[g][i] != word_counts[i])
					same = 1'b0;
			if (same) begin
				hit = 1'b1;
				r.idx = g[GrpW-1:0];
			end
		end
		if (!hit) begin
			if (groups_seen < MaxGroups) begin
				r.idx = groups_seen[GrpW-1:0];
				known_sigs[groups_seen] = word_counts;
				groups_seen++;
				r.is_new = 1'b1;
			end else begin
				r.full = 1'b1;
				full_hits++;
			end
		end
		r.sat = word_sat;
		if (word_sat)
			sat_hits++;
		group_answers = {group_answers, r};
		foreach (word_counts[i])
			word_counts[i] = '0;
		word_sat = 1'b0;
	endfunction

	// send one beat; random gaps come before it unless gaps are switched off
	// start stays high after the beat; the next beat replaces it or an idle gap takes it down
	task automatic send_beat(logic [4:0] code, logic vld, logic fin);
		while (!no_gaps && $urandom_range(99) < 21) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		letter <= code;
		letter_valid <= vld;
		word_end <= fin;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_beat(code, vld, fin);
		beats_sent++;
		if (fin)
			words_sent++;
	endtask

	// a word of given length; letters drawn from a small or full alphabet
	task automatic send_word(int len, int span);
		for (int i = 0; i < len; i++)
			send_beat(5'($urandom_range(span - 1)), 1'b1, i == len - 1);
		if (len == 0)
			send_beat(5'($urandom_range(31)), 1'b0, 1'b1);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (group_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// result checker: every done beat against the oldest expectation
	always @(posedge clk) begin
		res_t e;
		if (arst_n && done) begin
			if (group_answers.size() == 0) begin
				$error("unexpected result beat, group_index %0d", group_index);
				fail_count++;
			end else begin
				e = group_answers.pop_front();
				if (group_index !== e.idx) begin
					$error("group_index expected %0d actual %0d", e.idx, group_index);
					fail_count++;
				end
				if (new_group !== e.is_new) begin
					$error("new_group expected %0b actual %0b", e.is_new, new_group);
					fail_count++;
				end
				if (table_full !== e.full) begin
					$error("table_full expected %0b actual %0b", e.full, table_full);
					fail_count++;
				end
				if (count_saturated !== e.sat) begin
					$error("count_saturated expected %0b actual %0b", e.sat,
						count_saturated);
					fail_count++;
				end
			end
		end
	end

	// watchdog: cycles with neither an input beat nor a result beat
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > StallLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// directed: letter extremes, ignored codes, empty word, anagram repeats
	task automatic test_directed();
		send_beat(5'd0, 1'b0, 1'b1);
		send_beat(5'd0, 1'b1, 1'b1);
		send_beat(5'd25, 1'b1, 1'b1);
		send_beat(5'd26, 1'b1, 1'b0);
		send_beat(5'd31, 1'b1, 1'b1);
		send_beat(5'd1, 1'b1, 1'b0);
		send_beat(5'd0, 1'b1, 1'b0);
		send_beat(5'd2, 1'b0, 1'b1);
		send_beat(5'd0, 1'b1, 1'b0);
		send_beat(5'd1, 1'b1, 1'b1);
		send_beat(5'd21, 1'b1, 1'b0);
		send_beat(5'd10, 1'b1, 1'b1);
	endtask

	// a word that pushes one letter past saturation, and its exact-limit twin
	task automatic test_saturation();
		for (int i = 0; i < 70; i++)
			send_beat(5'd7, 1'b1, i == 69);
		for (int i = 0; i < MaxWordLen; i++)
			send_beat(5'd7, 1'b1, i == MaxWordLen - 1);
	endtask

	// pause until all answers are in, then run a burst with no gaps
	task automatic test_pause_burst();
		wait_drained();
		no_gaps = 1'b1;
		for (int i = 0; i < 40; i++)
			send_word($urandom_range(1, 3), 3);
		no_gaps = 1'b0;
	endtask

	// random words, mostly short over few letters so groups repeat
	task automatic test_random(int n_beats);
		int len;
		while (beats_sent < n_beats) begin
			case ($urandom_range(9))
				0: len = 0;
				1: len = $urandom_range(4, 12);
				default: len = $urandom_range(1, 3);
			endcase
			send_word(len, ($urandom_range(3) == 0) ? 32 : 4);
		end
	endtask

	// send random words until the table is full, then hit it full with old and new ones
	task automatic test_table_full();
		while (groups_seen < MaxGroups)
			send_word($urandom_range(1, 4), 26);
		for (int i = 0; i < 60; i++)
			send_word($urandom_range(0, 5), 26);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		letter = '0;
		letter_valid = 1'b0;
		word_end = 1'b0;
		foreach (word_counts[i])
			word_counts[i] = '0;
		groups_seen = 0;
		word_sat = 1'b0;
		fail_count = 0;
		idle_cycles = 0;
		words_sent = 0;
		beats_sent = 0;
		full_hits = 0;
		sat_hits = 0;
		no_gaps = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_saturation();
		test_pause_burst();
		test_random(1000);
		test_table_full();
		test_random(1800);
		wait_drained();
		repeat (2 * MaxGroups + 10) @(posedge clk);
		$display("covered %0d beats in %0d words, %0d saturated, %0d on a full table",
			beats_sent, words_sent, sat_hits, full_hits);
		if (fail_count == 0 && group_answers.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

FILE: files.f
rtl/agl_pkg.sv
rtl/agl_front.sv
rtl/agl_queue.sv
rtl/agl_back.sv
rtl/anagram_group_letter_count.sv
verif/anagram_group_letter_count_test.sv
